[rtl/pwle_pkg.sv]
// Shared types and constants for the piecewise-linear envelope block.
// Used by pwle_ctrl, pwle_dpath and piecewise_linear_envelope; no dependencies.
`default_nettype none

package pwle_pkg;

    // Field widths that do not vary
    localparam int ACT_W = 2;
    localparam int PT_W  = 24;
    localparam int LVL_W = 16;
    localparam int DUR_W = 24;

    // Quotient bits: every interpolation quotient is bounded by a level difference
    localparam int QW = 16;

    // Action codes of an input item
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

    // Reset values
    localparam logic [DUR_W-1:0]        DUR_RESET = 24'd48000;
    localparam logic signed [LVL_W-1:0] LVL_ONE   = 16'sd32767;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;     // latch the breakpoint fields of an accepted item
        logic init_add;    // point the index at the top of the table
        logic init_tick;   // point the index at the first entry
        logic clr_clock;   // restart the sample clock
        logic rd;          // read the table
        logic rd_below;    // read the entry under the index instead of at it
        logic shift;       // move the entry just read up one place
        logic write_new;   // write the new breakpoint at the index
        logic next;        // keep the entry read as previous point, advance index
        logic set_interp;  // load attack or between-points operands
        logic set_release; // load release operands
        logic set_zero;    // force a zero level
        logic mul;         // form the product into the divider
        logic dstep;       // one restoring divide step
        logic fin;         // add base and signed quotient into the held level
        logic out_load;    // advance the clock and load the result register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic idx_one;
        logic idx_last;
        logic rd_le_new;
        logic clk_lt_rd;
        logic clk_ge_dur;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/pwle_ctrl.sv]
// Sequencing state machine for the envelope block.
// Depends on pwle_pkg; drives pwle_dpath through t_cmd and reads t_sts.
`default_nettype none

module pwle_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [pwle_pkg::ACT_W-1:0] i_action,
    input  wire pwle_pkg::t_sts            i_sts,
    output pwle_pkg::t_cmd                 o_cmd
);
    import pwle_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ARD  = 4'd1;
    localparam logic [3:0] S_ACMP = 4'd2;
    localparam logic [3:0] S_AWR  = 4'd3;
    localparam logic [3:0] S_TRD  = 4'd4;
    localparam logic [3:0] S_TCMP = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    case (i_action)
                        ACT_ADD: begin
                            o_cmd.init_add = 1'b1;
                            if (!i_sts.count_full) begin
                                n_state = i_sts.count_zero ? S_AWR : S_ARD;
                            end
                        end
                        ACT_START: begin
                            o_cmd.clr_clock = 1'b1;
                        end
                        ACT_TICK: begin
                            o_cmd.init_tick = 1'b1;
                            n_state = i_sts.count_zero ? S_OUT : S_TRD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ARD: begin
                o_cmd.rd       = 1'b1;
                o_cmd.rd_below = 1'b1;
                n_state        = S_ACMP;
            end
            S_ACMP: begin
                // Stop at the first stored point not later than the new one
                if (i_sts.rd_le_new) begin
                    n_state = S_AWR;
                end else begin
                    o_cmd.shift = 1'b1;
                    n_state     = i_sts.idx_one ? S_AWR : S_ARD;
                end
            end
            S_AWR: begin
                o_cmd.write_new = 1'b1;
                n_state         = S_IDLE;
            end
            S_TRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_TCMP;
            end
            S_TCMP: begin
                // Find the segment that holds the sample clock
                if (i_sts.clk_lt_rd) begin
                    o_cmd.set_interp = 1'b1;
                    n_state          = S_MUL;
                end else if (i_sts.idx_last) begin
                    if (i_sts.clk_ge_dur) begin
                        o_cmd.set_zero = 1'b1;
                        n_state        = S_FIN;
                    end else begin
                        o_cmd.set_release = 1'b1;
                        n_state           = S_MUL;
                    end
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_TRD;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.dstep = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // Hold until the result register is free
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/pwle_dpath.sv]
// Datapath: breakpoint table, sample clock, multiplier, restoring divider, result register.
// Depends on pwle_pkg; commanded by pwle_ctrl through t_cmd, reports through t_sts.
`default_nettype none

module pwle_dpath #(
    parameter int MAX_POINTS = 16,
    parameter int TIME_BITS  = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire pwle_pkg::t_cmd                   i_cmd,
    output pwle_pkg::t_sts                        o_sts,
    input  wire logic                             i_cfg_we,
    input  wire logic [pwle_pkg::DUR_W-1:0]       i_cfg_data,
    input  wire logic [pwle_pkg::PT_W-1:0]        i_point_time,
    input  wire logic signed [pwle_pkg::LVL_W-1:0] i_point_level,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [pwle_pkg::LVL_W-1:0]     o_level,
    output logic                                  o_running
);
    import pwle_pkg::*;

    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int CW   = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
    localparam int NW   = QW + CW;
    localparam int DCW  = $clog2(QW + 1);

    // Breakpoint table
    logic [TIME_BITS-1:0]    r_mem_time  [MAX_POINTS];
    logic signed [LVL_W-1:0] r_mem_level [MAX_POINTS];

    logic [CNTW-1:0]         r_count;
    logic [TIME_BITS-1:0]    r_clock;
    logic signed [LVL_W-1:0] r_last;
    logic [DUR_W-1:0]        r_dur;
    logic [TIME_BITS-1:0]    r_new_time;
    logic signed [LVL_W-1:0] r_new_level;
    logic [IW-1:0]           r_idx;
    logic [TIME_BITS-1:0]    r_rd_time;
    logic signed [LVL_W-1:0] r_rd_level;
    logic [TIME_BITS-1:0]    r_prev_time;
    logic signed [LVL_W-1:0] r_prev_level;
    logic [QW-1:0]           r_a_mag;
    logic                    r_neg;
    logic [CW-1:0]           r_b;
    logic [CW-1:0]           r_den;
    logic signed [LVL_W-1:0] r_base;
    logic [CW-1:0]           r_rem;
    logic [QW-1:0]           r_lo;
    logic [DCW-1:0]          r_dcnt;
    logic                    r_out_valid;

    logic [IW-1:0]           w_rd_addr;
    logic                    w_wr_en;
    logic [TIME_BITS-1:0]    w_wr_time;
    logic signed [LVL_W-1:0] w_wr_level;
    logic [CW-1:0]           w_clk_x;
    logic [CW-1:0]           w_dur_x;
    logic [TIME_BITS-1:0]    w_clk_next;
    logic [LVL_W:0]          w_a;
    logic [LVL_W:0]          w_a_mag;
    logic [CW-1:0]           w_b;
    logic [CW-1:0]           w_den;
    logic signed [LVL_W-1:0] w_base;
    logic [NW-1:0]           w_prod;
    logic [CW:0]             w_trial;
    logic [CW:0]             w_diff;
    logic                    w_ge;
    logic [LVL_W:0]          w_q_s;
    logic [LVL_W:0]          w_sum;

    assign w_clk_x    = CW'(r_clock);
    assign w_dur_x    = CW'(r_dur);
    assign w_clk_next = (&r_clock) ? r_clock : r_clock + 1'b1;

    // Table access: one read and one write a cycle
    assign w_rd_addr  = i_cmd.rd_below ? r_idx - IW'(1) : r_idx;
    assign w_wr_en    = i_cmd.shift || i_cmd.write_new;
    assign w_wr_time  = i_cmd.shift ? r_rd_time : r_new_time;
    assign w_wr_level = i_cmd.shift ? r_rd_level : r_new_level;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_time[r_idx]  <= w_wr_time;
            r_mem_level[r_idx] <= w_wr_level;
        end
        if (i_cmd.rd) begin
            r_rd_time  <= r_mem_time[w_rd_addr];
            r_rd_level <= r_mem_level[w_rd_addr];
        end
    end

    // Segment operands: attack from the origin, between points, or release
    always_comb begin
        if (i_cmd.set_release) begin
            w_a    = {r_rd_level[LVL_W-1], r_rd_level};
            w_b    = w_dur_x - w_clk_x;
            w_den  = w_dur_x - CW'(r_rd_time);
            w_base = '0;
        end else if (r_idx == '0) begin
            w_a    = {r_rd_level[LVL_W-1], r_rd_level};
            w_b    = w_clk_x;
            w_den  = CW'(r_rd_time);
            w_base = '0;
        end else begin
            w_a    = {r_rd_level[LVL_W-1], r_rd_level}
                   - {r_prev_level[LVL_W-1], r_prev_level};
            w_b    = CW'(r_clock - r_prev_time);
            w_den  = CW'(r_rd_time - r_prev_time);
            w_base = r_prev_level;
        end
    end

    assign w_a_mag = w_a[LVL_W] ? (~w_a + 1'b1) : w_a;

    // Magnitude product, then restoring divide on the top part
    assign w_prod  = r_a_mag * r_b;
    assign w_trial = {r_rem, r_lo[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // Apply sign to the quotient and add the segment base
    assign w_q_s = r_neg ? (~{1'b0, r_lo} + 1'b1) : {1'b0, r_lo};
    assign w_sum = {r_base[LVL_W-1], r_base} + w_q_s;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clock     <= '0;
            r_last      <= LVL_ONE;
            r_dur       <= DUR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dur <= i_cfg_data;
            end
            if (i_cmd.write_new) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.clr_clock) begin
                r_clock <= '0;
            end else if (i_cmd.out_load) begin
                r_clock <= w_clk_next;
            end
            if (i_cmd.fin) begin
                r_last <= w_sum[LVL_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_new_time  <= TIME_BITS'(i_point_time);
            r_new_level <= i_point_level;
        end
        if (i_cmd.init_add) begin
            r_idx <= IW'(r_count);
        end else if (i_cmd.init_tick) begin
            r_idx <= '0;
        end else if (i_cmd.shift) begin
            r_idx <= r_idx - IW'(1);
        end else if (i_cmd.next) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.next) begin
            r_prev_time  <= r_rd_time;
            r_prev_level <= r_rd_level;
        end
        if (i_cmd.set_interp || i_cmd.set_release) begin
            r_a_mag <= w_a_mag[QW-1:0];
            r_neg   <= w_a[LVL_W];
            r_b     <= w_b;
            r_den   <= w_den;
            r_base  <= w_base;
        end else if (i_cmd.set_zero) begin
            r_neg  <= 1'b0;
            r_base <= '0;
        end
        if (i_cmd.set_zero) begin
            r_lo <= '0;
        end else if (i_cmd.mul) begin
            r_rem  <= w_prod[NW-1:QW];
            r_lo   <= w_prod[QW-1:0];
            r_dcnt <= DCW'(QW);
        end else if (i_cmd.dstep) begin
            r_rem  <= w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
            r_lo   <= {r_lo[QW-2:0], w_ge};
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.out_load) begin
            o_level   <= r_last;
            o_running <= (CW'(w_clk_next) < w_dur_x);
        end
    end

    assign o_out_valid = r_out_valid;

    // Status
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.count_full = (r_count == CNTW'(MAX_POINTS));
    assign o_sts.idx_one    = (r_idx == IW'(1));
    assign o_sts.idx_last   = ((CNTW'(r_idx) + 1'b1) == r_count);
    assign o_sts.rd_le_new  = (r_rd_time <= r_new_time);
    assign o_sts.clk_lt_rd  = (r_clock < r_rd_time);
    assign o_sts.clk_ge_dur = (w_clk_x >= w_dur_x);
    assign o_sts.div_last   = (r_dcnt == DCW'(1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

[rtl/piecewise_linear_envelope.sv]
// Top level of the piecewise-linear breakpoint envelope generator.
// Depends on pwle_pkg, pwle_ctrl and pwle_dpath.
//
//  Port group  Direction  Handshake                   Payload
//  in          input      i_in_valid / o_in_ready     i_action, i_point_time, i_point_level
//  out         output     o_out_valid / i_out_ready   o_level, o_running
//  cfg         input      i_cfg_we (no wait)          i_cfg_data (duration)
//
// One item at a time. A tick reads the table entries one by one to find its segment
// (one read port), then multiplies and runs the 16-step divider; past the last entry
// with the clock at the duration it skips both, and with an empty table it loads the held level.
// An add moves the later entries up one by one; start and full-table adds end on acceptance.
// Reset is synchronous, active low, and needs no clearing pass.
// A waiting result blocks the input only while a tick waits for it in its final load.
`default_nettype none

module piecewise_linear_envelope #(
    parameter int MAX_POINTS = 16,
    parameter int TIME_BITS  = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [pwle_pkg::ACT_W-1:0]       i_action,
    input  wire logic [pwle_pkg::PT_W-1:0]        i_point_time,
    input  wire logic signed [pwle_pkg::LVL_W-1:0] i_point_level,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [pwle_pkg::LVL_W-1:0]     o_level,
    output logic                                  o_running,
    input  wire logic                             i_cfg_we,
    input  wire logic [pwle_pkg::DUR_W-1:0]       i_cfg_data
);
    import pwle_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    pwle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Table, arithmetic and result register
    pwle_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .TIME_BITS  (TIME_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_point_time  (i_point_time),
        .i_point_level (i_point_level),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_level       (o_level),
        .o_running     (o_running)
    );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking bench for piecewise_linear_envelope: directed table, then random notes.
// Depends on pwle_pkg and the piecewise_linear_envelope RTL; needs nothing else.
`timescale 1ns / 1ps

module testbench;
    import pwle_pkg::*;

    localparam int MAX_BP        = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int N_PHASES      = 9;
    localparam int PHASE_ITEMS   = 140;
    localparam int CALM_PHASE    = 3;
    localparam int HOLD_PHASE    = 5;
    localparam int HOLD_CYCLES   = 400;
    localparam int N_ROWS        = 16;

    // Action code that the block has no use for
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [PT_W-1:0]  CLOCK_MAX  = '1;

    typedef struct packed {
        logic signed [LVL_W-1:0] level;
        logic                    running;
    } env_sample_t;

    typedef struct packed {
        logic [ACT_W-1:0]        act;
        logic [PT_W-1:0]         t;
        logic signed [LVL_W-1:0] lv;
        logic [7:0]              reps;
        logic                    typed;
        logic signed [LVL_W-1:0] exp_level;
        logic                    exp_running;
    } stim_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [ACT_W-1:0]        i_action;
    logic [PT_W-1:0]         i_point_time;
    logic signed [LVL_W-1:0] i_point_level;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [LVL_W-1:0] o_level;
    logic                    o_running;
    logic                    i_cfg_we;
    logic [DUR_W-1:0]        i_cfg_data;

    // Envelope state as the testbench sees it
    bit [PT_W-1:0]           bp_time [MAX_BP];
    logic signed [LVL_W-1:0] bp_level [MAX_BP];
    int                      bp_count;
    bit [PT_W-1:0]           smp_clock;
    logic signed [LVL_W-1:0] held_level;
    bit [DUR_W-1:0]          note_len;

    env_sample_t pending_samples[$];
    int          n_errors;
    int          n_items;
    int          n_samples;
    int          n_settings;
    bit          calm;
    int          hold_requests;

    // Directed items: empty table, unused action, attack, equal times, extremes, release
    stim_row_t directed_rows [N_ROWS] = '{
        '{ACT_TICK,   24'd0,      16'sd0,      8'd1,  1'b1, 16'sd32767, 1'b1},
        '{ACT_UNUSED, 24'hFFFFFF, -16'sd1,     8'd1,  1'b0, 16'sd0,     1'b0},
        '{ACT_TICK,   24'hFFFFFF, 16'sd32767,  8'd1,  1'b1, 16'sd32767, 1'b1},
        '{ACT_START,  24'h000000, -16'sd32768, 8'd1,  1'b0, 16'sd0,     1'b0},
        '{ACT_TICK,   24'h5A5A5A, 16'sd0,      8'd1,  1'b1, 16'sd32767, 1'b1},
        '{ACT_ADD,    24'd40,     16'sd32767,  8'd1,  1'b0, 16'sd0,     1'b0},
        '{ACT_TICK,   24'd0,      16'sd0,      8'd1,  1'b0, 16'sd0,     1'b0},
        '{ACT_TICK,   24'd0,      16'sd0,      8'd1,  1'b0, 16'sd0,     1'b0},
        '{ACT_ADD,    24'd20,     -16'sd32768, 8'd1,  1'b0, 16'sd0,     1'b0},
        '{ACT_ADD,    24'd40,     16'sd0,      8'd1,  1'b0, 16'sd0,     1'b0},
        '{ACT_ADD,    24'd70,     -16'sd16384, 8'd1,  1'b0, 16'sd0,     1'b0},
        '{ACT_START,  24'hFFFFFF, 16'sd32767,  8'd1,  1'b0, 16'sd0,     1'b0},
        '{ACT_TICK,   24'd0,      16'sd0,      8'd1,  1'b1, 16'sd0,     1'b1},
        '{ACT_TICK,   24'hA5A5A5, 16'sd21845,  8'd80, 1'b0, 16'sd0,     1'b0},
        '{ACT_UNUSED, 24'd0,      16'sd0,      8'd1,  1'b0, 16'sd0,     1'b0},
        '{ACT_TICK,   24'd0,      -16'sd21846, 8'd2,  1'b0, 16'sd0,     1'b0}
    };

    piecewise_linear_envelope u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_point_time  (i_point_time),
        .i_point_level (i_point_level),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_level       (o_level),
        .o_running     (o_running),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Level of the envelope at sample time t; the table must not be empty
    function automatic logic signed [LVL_W-1:0] level_at(bit [PT_W-1:0] t);
        int     last;
        int     nx;
        longint tl;
        longint tp;
        longint tq;
        longint lp;
        longint ln;
        longint dl;
        last = bp_count - 1;
        tl   = t;
        if (t < bp_time[0]) begin
            lp = bp_level[0];
            tq = bp_time[0];
            return LVL_W'(lp * tl / tq);
        end
        if (t < bp_time[last]) begin
            nx = 1;
            while (nx < last && bp_time[nx] <= t) nx++;
            lp = bp_level[nx-1];
            ln = bp_level[nx];
            tp = bp_time[nx-1];
            tq = bp_time[nx];
            return LVL_W'(lp + (ln - lp) * (tl - tp) / (tq - tp));
        end
        if (t >= note_len) return '0;
        dl = note_len;
        tq = bp_time[last];
        lp = bp_level[last];
        return LVL_W'(lp * (dl - tl) / (dl - tq));
    endfunction

    // Advance the envelope state by one item; return 1 when it gives a sample
    function automatic bit envelope_step(input logic [ACT_W-1:0] act,
                                         input logic [PT_W-1:0] t,
                                         input logic signed [LVL_W-1:0] lv,
                                         output env_sample_t s);
        int pos;
        int k;
        s = '0;
        case (act)
            ACT_ADD: begin
                if (bp_count < MAX_BP) begin
                    pos = 0;
                    while (pos < bp_count && bp_time[pos] <= t) pos++;
                    for (k = bp_count; k > pos; k--) begin
                        bp_time[k]  = bp_time[k-1];
                        bp_level[k] = bp_level[k-1];
                    end
                    bp_time[pos]  = t;
                    bp_level[pos] = lv;
                    bp_count++;
                end
                return 1'b0;
            end
            ACT_START: begin
                smp_clock = '0;
                return 1'b0;
            end
            ACT_TICK: begin
                if (bp_count > 0) held_level = level_at(smp_clock);
                if (smp_clock != CLOCK_MAX) smp_clock++;
                s.level   = held_level;
                s.running = (smp_clock < note_len);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Offer one item, hold it until accepted, then book its expected sample
    task automatic put_item(input logic [ACT_W-1:0] act, input logic [PT_W-1:0] t,
                            input logic signed [LVL_W-1:0] lv,
                            input bit typed, input env_sample_t typed_s);
        env_sample_t s;
        while (!calm && $urandom_range(0, 99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_point_time  <= t;
        i_point_level <= lv;
        do @(posedge i_clk); while (!o_in_ready);
        n_items++;
        if (envelope_step(act, t, lv, s)) begin
            pending_samples.insert(pending_samples.size(), typed ? typed_s : s);
        end
    endtask

    // Drain the block, let any add finish, then write the note length
    task automatic set_note_length(input bit [DUR_W-1:0] d);
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        note_len = d;
        n_settings++;
    endtask

    function automatic logic signed [LVL_W-1:0] random_level();
        case ($urandom_range(0, 7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            default: return LVL_W'($urandom);
        endcase
    endfunction

    // One note: maybe grow the table, usually restart the clock, then a run of mostly ticks
    task automatic play_note(inout int done);
        int n_add;
        int len;
        int j;
        int pick;
        if (bp_count < MAX_BP) begin
            n_add = $urandom_range(0, 2);
            for (j = 0; j < n_add; j++) begin
                put_item(ACT_ADD, PT_W'($urandom_range(0, 180)), random_level(), 1'b0, '0);
                done++;
            end
        end else if ($urandom_range(0, 2) == 0) begin
            // table full: the add must be dropped
            put_item(ACT_ADD, PT_W'($urandom), LVL_W'($urandom), 1'b0, '0);
        end
        if ($urandom_range(0, 99) < 85) begin
            put_item(ACT_START, PT_W'($urandom), LVL_W'($urandom), 1'b0, '0);
            done++;
        end
        // Keep the phase close to its item budget
        len = $urandom_range(1, 250);
        if (len > PHASE_ITEMS - done) len = (PHASE_ITEMS - done > 0) ? PHASE_ITEMS - done : 1;
        for (j = 0; j < len; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                put_item(ACT_UNUSED, PT_W'($urandom), LVL_W'($urandom), 1'b0, '0);
            end else begin
                put_item(pick < 5 ? ACT_START : ACT_TICK, PT_W'($urandom),
                         LVL_W'($urandom), 1'b0, '0);
                done++;
            end
        end
    endtask

    // Check each sample against the oldest expectation and pick the next ready
    always @(posedge i_clk) begin
        env_sample_t want;
        int hold_left;
        int hold_seen;
        if (i_out_ready && o_out_valid) begin
            n_samples++;
            if (pending_samples.size() == 0) begin
                $error("unexpected sample: level %0d running %0b", o_level, o_running);
                n_errors++;
            end else begin
                want = pending_samples.pop_front();
                if (o_level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, o_level);
                    n_errors++;
                end
                if (o_running !== want.running) begin
                    $error("running: expected %0b, got %0b", want.running, o_running);
                    n_errors++;
                end
            end
        end
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 24);
        end
    end

    // Stimulus and end of run
    initial begin
        stim_row_t   row;
        env_sample_t typed_s;
        int          r;
        int          j;
        int          phase;
        int          done;
        bit [DUR_W-1:0] d;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = ACT_TICK;
        i_point_time  = '0;
        i_point_level = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        bp_count      = 0;
        smp_clock     = '0;
        held_level    = LVL_ONE;
        note_len      = DUR_RESET;
        n_errors      = 0;
        n_items       = 0;
        n_samples     = 0;
        n_settings    = 0;
        calm          = 1'b0;
        hold_requests = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table at the reset note length
        for (r = 0; r < N_ROWS; r++) begin
            row     = directed_rows[r];
            typed_s = '{level: row.exp_level, running: row.exp_running};
            for (j = 0; j < row.reps; j++) put_item(row.act, row.t, row.lv, row.typed, typed_s);
        end

        // Random notes, one note-length setting per phase
        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0:       d = '1;
                1:       d = 24'd1;
                2:       d = 24'd0;
                default: d = DUR_W'($urandom_range(40, 400));
            endcase
            set_note_length(d);
            calm = (phase == CALM_PHASE);
            if (phase == HOLD_PHASE) hold_requests++;
            done = 0;
            while (done < PHASE_ITEMS) play_note(done);
        end
        calm = 1'b0;

        // Let the last samples drain
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items and checked %0d samples over %0d note-length settings,",
                 n_items, n_samples, n_settings + 1);
        $display("with %0d breakpoints stored out of %0d.", bp_count, MAX_BP);
        if (n_errors == 0) begin
            $display("** piecewise_linear_envelope: PASSED **");
        end else begin
            $display("** piecewise_linear_envelope: FAILED **");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #20_000_000;
        $display("timeout with %0d samples still expected", pending_samples.size());
        $display("** piecewise_linear_envelope: FAILED **");
        $finish;
    end

endmodule
